// ===== hdl/msf_pkg.sv =====
// Shared types and sizes for the minimum spanning forest block.
// No dependencies; imported by the top level.
`default_nettype none
package msf_pkg;

   localparam int VERT_BITS   = 6;
   localparam int NUM_VERTS   = 64;
   localparam int EADDR_BITS  = 8;
   localparam int MAX_EDGES   = 256;
   localparam int CNT_BITS    = 9;
   localparam int WEIGHT_BITS = 32;
   localparam int RANK_BITS   = 3;
   localparam int VC_BITS     = 7;
   localparam logic [VC_BITS-1:0] VC_RESET = 7'd64;

   // One stored edge: endpoints and signed weight
   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] weight;
      logic [VERT_BITS-1:0]          to_v;
      logic [VERT_BITS-1:0]          from_v;
   } edge_type;

endpackage
`default_nettype wire

// ===== hdl/minimum_spanning_forest_top.sv =====
// Minimum spanning forest: edge store, in-place stable insertion sort and Kruskal
// scan over a union-find store. Depends on msf_pkg.
// Edge beats are taken one per cycle while loading, only in the idle state. After the last
// beat the sort runs (when more than one edge is stored), then the union-find store is
// initialized, then the scan runs and can stall on result back-pressure. One graph at a time.
// Reset (synchronous): vertex_count 64, edge count and drop flag clear; memories keep data.
`default_nettype none
module minimum_spanning_forest_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // from_vertex[5:0], to_vertex[11:6], edge_weight[43:12]
   input  wire logic        req_tlast,   // last_edge
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // tree_from[6:0], tree_to[13:7], tree_weight[45:14]
   output logic             rsp_tlast,   // final_result
   output logic [1:0]       rsp_tuser,   // forest_empty[0], edges_dropped[1]
   input  wire logic        csr_wr_en,
   input  wire logic [msf_pkg::VC_BITS-1:0] csr_wr_data
);
   import msf_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SORT_LD  = 4'd1;
   localparam logic [3:0] S_SORT_KEY = 4'd2;
   localparam logic [3:0] S_SORT_CMP = 4'd3;
   localparam logic [3:0] S_SORT_PUT = 4'd4;
   localparam logic [3:0] S_INIT     = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CHK = 4'd7;
   localparam logic [3:0] S_FIND_RD  = 4'd8;
   localparam logic [3:0] S_FIND_CK  = 4'd9;
   localparam logic [3:0] S_COMP     = 4'd10;
   localparam logic [3:0] S_EMIT     = 4'd11;
   localparam logic [3:0] S_UN_A     = 4'd12;
   localparam logic [3:0] S_UN_B     = 4'd13;
   localparam logic [3:0] S_FIN      = 4'd14;

   // Control and payload registers
   logic [3:0]            state_ff, state_in;
   logic [VC_BITS-1:0]    vc_ff, vc_in;
   logic [CNT_BITS-1:0]   total_ff, total_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [EADDR_BITS-1:0] pos_ff, pos_in;
   edge_type              key_ff, key_in;
   edge_type              edge_ff, edge_in;
   logic [VERT_BITS-1:0]  cur_ff, cur_in;
   logic [VERT_BITS-1:0]  start_ff, start_in;
   logic [VERT_BITS-1:0]  root_ff, root_in;
   logic [VERT_BITS-1:0]  root_a_ff, root_a_in;
   logic [VERT_BITS-1:0]  root_b_ff, root_b_in;
   logic                  phase_ff, phase_in;
   logic [RANK_BITS-1:0]  rank_a_ff, rank_a_in;
   edge_type              pend_ff, pend_in;
   logic                  pend_v_ff, pend_v_in;
   logic                  out_v_ff, out_v_in;
   edge_type              out_e_ff, out_e_in;
   logic                  out_fin_ff, out_fin_in;
   logic                  out_emp_ff, out_emp_in;
   logic                  out_drop_ff, out_drop_in;

   // Memory ports
   edge_type              edge_mem [MAX_EDGES];
   logic                  em_we;
   logic [EADDR_BITS-1:0] em_waddr, em_raddr;
   edge_type              em_wdata, em_rdata_ff;
   logic [VERT_BITS-1:0]  link_mem [NUM_VERTS];
   logic                  lk_we;
   logic [VERT_BITS-1:0]  lk_waddr, lk_raddr, lk_wdata, lk_rdata_ff;
   logic [RANK_BITS-1:0]  rank_mem [NUM_VERTS];
   logic                  rk_we;
   logic [VERT_BITS-1:0]  rk_waddr, rk_raddr;
   logic [RANK_BITS-1:0]  rk_wdata, rk_rdata_ff;

   // Helpers
   edge_type              in_edge;
   logic                  in_ok;
   logic                  req_acc;
   logic                  out_free;
   logic                  fnd;
   logic [VERT_BITS-1:0]  fnd_root;
   logic                  next_e;
   logic                  next_i;
   logic [CNT_BITS-1:0]   n_load;
   logic [CNT_BITS-1:0]   idx_inc;

   assign in_edge  = edge_type'(req_tdata[43:0]);
   assign in_ok    = ({1'b0, in_edge.from_v} < vc_ff) && ({1'b0, in_edge.to_v} < vc_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !out_v_ff || rsp_tready;
   assign idx_inc  = idx_ff + 1'b1;

   // Next-state logic for the load, sort and scan sequencer
   always_comb begin
      state_in  = state_ff;
      vc_in     = csr_wr_en ? csr_wr_data : vc_ff;
      total_in  = total_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      edge_in   = edge_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      root_in   = root_ff;
      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      phase_in  = phase_ff;
      rank_a_in = rank_a_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      out_e_in  = out_e_ff;
      out_fin_in  = out_fin_ff;
      out_emp_in  = out_emp_ff;
      out_drop_in = out_drop_ff;
      em_we    = 1'b0;
      em_waddr = total_ff[EADDR_BITS-1:0];
      em_wdata = in_edge;
      em_raddr = idx_ff[EADDR_BITS-1:0];
      lk_we    = 1'b0;
      lk_waddr = cur_ff;
      lk_wdata = root_ff;
      lk_raddr = cur_ff;
      rk_we    = 1'b0;
      rk_waddr = idx_ff[VERT_BITS-1:0];
      rk_wdata = '0;
      rk_raddr = root_a_ff;
      fnd      = 1'b0;
      fnd_root = cur_ff;
      next_e   = 1'b0;
      next_i   = 1'b0;
      n_load   = total_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (in_ok) begin
                  if (total_ff < CNT_BITS'(MAX_EDGES)) begin
                     em_we    = 1'b1;
                     total_in = total_ff + 1'b1;
                     n_load   = total_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_tlast) begin
                  if (n_load > CNT_BITS'(1)) begin
                     idx_in   = CNT_BITS'(1);
                     state_in = S_SORT_LD;
                  end else begin
                     idx_in   = '0;
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_SORT_LD: begin
            state_in = S_SORT_KEY;
         end
         S_SORT_KEY: begin
            key_in   = em_rdata_ff;
            pos_in   = idx_ff[EADDR_BITS-1:0];
            em_raddr = idx_ff[EADDR_BITS-1:0] - 1'b1;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            em_we    = 1'b1;
            em_waddr = pos_ff;
            if (em_rdata_ff.weight > key_ff.weight) begin
               // shift the larger entry up one place
               em_wdata = em_rdata_ff;
               pos_in   = pos_ff - 1'b1;
               if (pos_ff != EADDR_BITS'(1)) begin
                  em_raddr = pos_ff - EADDR_BITS'(2);
               end else begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               em_wdata = key_ff;
               next_i   = 1'b1;
            end
         end
         S_SORT_PUT: begin
            em_we    = 1'b1;
            em_waddr = pos_ff;
            em_wdata = key_ff;
            next_i   = 1'b1;
         end
         S_INIT: begin
            lk_we    = 1'b1;
            lk_waddr = idx_ff[VERT_BITS-1:0];
            lk_wdata = idx_ff[VERT_BITS-1:0];
            rk_we    = 1'b1;
            idx_in   = idx_inc;
            if (idx_ff[VERT_BITS-1:0] == VERT_BITS'(NUM_VERTS - 1)) begin
               idx_in   = '0;
               state_in = (total_ff == '0) ? S_FIN : S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            edge_in = em_rdata_ff;
            if (({1'b0, em_rdata_ff.from_v} >= vc_ff) || ({1'b0, em_rdata_ff.to_v} >= vc_ff)) begin
               next_e = 1'b1;
            end else begin
               cur_in   = em_rdata_ff.from_v;
               start_in = em_rdata_ff.from_v;
               phase_in = 1'b0;
               state_in = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CK;
         end
         S_FIND_CK: begin
            if (lk_rdata_ff == cur_ff) begin
               root_in = cur_ff;
               if (start_ff == cur_ff) begin
                  fnd      = 1'b1;
                  fnd_root = cur_ff;
               end else begin
                  // compress the path from the start node
                  lk_raddr = start_ff;
                  cur_in   = start_ff;
                  state_in = S_COMP;
               end
            end else begin
               cur_in   = lk_rdata_ff;
               lk_raddr = lk_rdata_ff;
            end
         end
         S_COMP: begin
            lk_we    = 1'b1;
            lk_waddr = cur_ff;
            lk_wdata = root_ff;
            if (lk_rdata_ff == root_ff) begin
               fnd      = 1'b1;
               fnd_root = root_ff;
            end else begin
               cur_in   = lk_rdata_ff;
               lk_raddr = lk_rdata_ff;
            end
         end
         S_EMIT: begin
            if (root_a_ff == root_b_ff) begin
               next_e = 1'b1;
            end else if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_e_in    = pend_ff;
                  out_fin_in  = 1'b0;
                  out_emp_in  = 1'b0;
                  out_drop_in = ovf_ff;
               end
               pend_in   = edge_ff;
               pend_v_in = 1'b1;
               rk_raddr  = root_a_ff;
               state_in  = S_UN_A;
            end
         end
         S_UN_A: begin
            rank_a_in = rk_rdata_ff;
            rk_raddr  = root_b_ff;
            state_in  = S_UN_B;
         end
         S_UN_B: begin
            lk_we = 1'b1;
            if (rank_a_ff < rk_rdata_ff) begin
               lk_waddr = root_a_ff;
               lk_wdata = root_b_ff;
            end else begin
               lk_waddr = root_b_ff;
               lk_wdata = root_a_ff;
               if (rank_a_ff == rk_rdata_ff) begin
                  rk_we    = 1'b1;
                  rk_waddr = root_a_ff;
                  rk_wdata = rank_a_ff + 1'b1;
               end
            end
            next_e = 1'b1;
         end
         S_FIN: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_fin_in  = 1'b1;
               out_drop_in = ovf_ff;
               if (pend_v_ff) begin
                  out_e_in   = pend_ff;
                  out_emp_in = 1'b0;
               end else begin
                  out_e_in   = '0;
                  out_emp_in = 1'b1;
               end
               pend_v_in = 1'b0;
               total_in  = '0;
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Root found: go on to the second endpoint or to the emit decision
      if (fnd) begin
         if (!phase_ff) begin
            root_a_in = fnd_root;
            phase_in  = 1'b1;
            cur_in    = edge_ff.to_v;
            start_in  = edge_ff.to_v;
            state_in  = S_FIND_RD;
         end else begin
            root_b_in = fnd_root;
            state_in  = S_EMIT;
         end
      end

      // Advance the sort's outer index
      if (next_i) begin
         if (idx_inc < total_ff) begin
            idx_in   = idx_inc;
            state_in = S_SORT_LD;
         end else begin
            idx_in   = '0;
            state_in = S_INIT;
         end
      end

      // Advance the scan to the next sorted edge
      if (next_e) begin
         idx_in   = idx_inc;
         state_in = (idx_inc == total_ff) ? S_FIN : S_SCAN_RD;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vc_ff     <= VC_RESET;
         total_ff  <= '0;
         ovf_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         vc_ff     <= vc_in;
         total_ff  <= total_in;
         ovf_ff    <= ovf_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         idx_ff    <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      edge_ff     <= edge_in;
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      root_ff     <= root_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      phase_ff    <= phase_in;
      rank_a_ff   <= rank_a_in;
      pend_ff     <= pend_in;
      out_e_ff    <= out_e_in;
      out_fin_ff  <= out_fin_in;
      out_emp_ff  <= out_emp_in;
      out_drop_ff <= out_drop_in;
   end

   // Edge store
   always_ff @(posedge clock) begin
      if (em_we) begin
         edge_mem[em_waddr] <= em_wdata;
      end
      em_rdata_ff <= edge_mem[em_raddr];
   end

   // Union-find links
   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_waddr] <= lk_wdata;
      end
      lk_rdata_ff <= link_mem[lk_raddr];
   end

   // Union-find ranks
   always_ff @(posedge clock) begin
      if (rk_we) begin
         rank_mem[rk_waddr] <= rk_wdata;
      end
      rk_rdata_ff <= rank_mem[rk_raddr];
   end

   // Result beat
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_e_ff.weight,
                        {1'b0, out_e_ff.to_v} + {6'd0, !out_emp_ff},
                        {1'b0, out_e_ff.from_v} + {6'd0, !out_emp_ff}};
   assign rsp_tlast  = out_fin_ff;
   assign rsp_tuser  = {out_drop_ff, out_emp_ff};

   // Checks
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_BITS'(MAX_EDGES))
      else $error("edge count beyond store capacity");
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (total_ff == '0 && !ovf_ff && state_ff == S_IDLE))
      else $error("run end did not clear the edge count");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("empty forest beat carries data");
   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input taken during a run");

endmodule
`default_nettype wire

// ===== tb/tb_minimum_spanning_forest_top.sv =====
// Testbench for minimum_spanning_forest_top: loads edge graphs over the request
// stream and checks every tree edge beat against a built-in Kruskal predictor.
// Depends on msf_pkg and the top level RTL.
`timescale 1ns / 1ps
module tb_minimum_spanning_forest_top;
   import msf_pkg::*;

   // One expected tree edge beat
   typedef struct {
      logic [6:0]        from_v;
      logic [6:0]        to_v;
      logic signed [31:0] weight;
      bit                final_beat;
      bit                empty;
      bit                dropped;
   } tree_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [VC_BITS-1:0] csr_wr_data = '0;

   // Predictor state: shadow register and the graph being loaded
   logic [VC_BITS-1:0]    shadow_vc = VC_RESET;
   logic [VERT_BITS-1:0]  graph_from[$];
   logic [VERT_BITS-1:0]  graph_to[$];
   logic signed [31:0]    graph_wt[$];
   bit                    graph_overflow = 0;
   tree_beat_type         pending_tree[$];
   int                    fail_count = 0;
   bit                    calm = 0;

   always #10 clock = ~clock;

   minimum_spanning_forest_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Kruskal over the loaded graph; push the expected tree beats
   task automatic solve_forest();
      int order[$];
      int parent[64];
      int rank_of[64];
      int live, pos, cur, ra, rb, x, nx, cnt;
      tree_beat_type beat;
      live = (shadow_vc > 64) ? 64 : int'(shadow_vc);
      cnt = 0;
      // stable insertion sort by signed weight
      for (int i = 0; i < graph_wt.size(); i++) begin
         pos = order.size();
         while (pos > 0 && graph_wt[order[pos-1]] > graph_wt[i]) pos--;
         order.insert(pos, i);
      end
      for (int v = 0; v < 64; v++) begin
         parent[v] = v;
         rank_of[v] = 0;
      end
      foreach (order[k]) begin
         cur = order[k];
         // skip edges with an endpoint outside the live vertices
         if (int'(graph_from[cur]) >= live || int'(graph_to[cur]) >= live) continue;
         ra = int'(graph_from[cur]);
         while (parent[ra] != ra) ra = parent[ra];
         x = int'(graph_from[cur]);
         while (x != ra) begin
            nx = parent[x]; parent[x] = ra; x = nx;
         end
         rb = int'(graph_to[cur]);
         while (parent[rb] != rb) rb = parent[rb];
         x = int'(graph_to[cur]);
         while (x != rb) begin
            nx = parent[x]; parent[x] = rb; x = nx;
         end
         if (ra != rb && cnt < 63) begin
            beat.from_v = graph_from[cur] + 7'd1;
            beat.to_v = graph_to[cur] + 7'd1;
            beat.weight = graph_wt[cur];
            beat.final_beat = 0;
            beat.empty = 0;
            beat.dropped = graph_overflow;
            pending_tree.push_back(beat);
            cnt++;
            if (rank_of[ra] < rank_of[rb]) begin
               x = ra; ra = rb; rb = x;
            end
            parent[rb] = ra;
            if (rank_of[ra] == rank_of[rb]) rank_of[ra]++;
         end
      end
      if (cnt == 0) begin
         beat.from_v = '0;
         beat.to_v = '0;
         beat.weight = '0;
         beat.final_beat = 1;
         beat.empty = 1;
         beat.dropped = graph_overflow;
         pending_tree.push_back(beat);
      end else begin
         pending_tree[pending_tree.size()-1].final_beat = 1;
      end
      graph_from.delete();
      graph_to.delete();
      graph_wt.delete();
      graph_overflow = 0;
   endtask

   // Record one accepted edge beat in the predictor
   task automatic record_edge(logic [5:0] fv, logic [5:0] tv, logic signed [31:0] w,
                              bit last);
      int live;
      live = (shadow_vc > 64) ? 64 : int'(shadow_vc);
      if (int'(fv) < live && int'(tv) < live) begin
         if (graph_wt.size() < MAX_EDGES) begin
            graph_from.push_back(fv);
            graph_to.push_back(tv);
            graph_wt.push_back(w);
         end else begin
            graph_overflow = 1;
         end
      end
      if (last) solve_forest();
   endtask

   // Send one edge beat after a random gap, or none in calm mode, and wait for acceptance
   task automatic send_edge(logic [5:0] fv, logic [5:0] tv, logic signed [31:0] w,
                            bit last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, w, tv, fv};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      record_edge(fv, tv, w, last);
   endtask

   // Hold off until every expected beat is back, then let the block settle
   task automatic drain();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (pending_tree.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write vertex_count while the block is idle
   task automatic write_vertex_count(logic [VC_BITS-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_vc = value;
   endtask

   // Random content weight: full range or a narrow band that forces ties
   function automatic logic signed [31:0] pick_weight();
      return ($urandom_range(0, 1) == 0) ? $signed($urandom) : $urandom_range(0, 5) - 2;
   endfunction

   // Check each result beat against the oldest expectation
   initial begin
      int gap;
      tree_beat_type want;
      @(negedge reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_tree.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_tree.pop_front();
            if (rsp_tdata[6:0] !== want.from_v) begin
               $error("tree_from expected %0d actual %0d", want.from_v, rsp_tdata[6:0]);
               fail_count++;
            end
            if (rsp_tdata[13:7] !== want.to_v) begin
               $error("tree_to expected %0d actual %0d", want.to_v, rsp_tdata[13:7]);
               fail_count++;
            end
            if ($signed(rsp_tdata[45:14]) !== want.weight) begin
               $error("tree_weight expected %0d actual %0d", want.weight,
                      $signed(rsp_tdata[45:14]));
               fail_count++;
            end
            if (rsp_tlast !== want.final_beat) begin
               $error("final_result expected %0d actual %0d", want.final_beat, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.empty) begin
               $error("forest_empty expected %0d actual %0d", want.empty, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.dropped) begin
               $error("edges_dropped expected %0d actual %0d", want.dropped, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   // Extremes of weights and endpoints, self loop and tie order at reset count
   task automatic test_extremes();
      send_edge(6'd0, 6'd63, 32'sh8000_0000, 0);
      send_edge(6'd63, 6'd0, 32'sh7FFF_FFFF, 0);
      send_edge(6'd5, 6'd5, 32'sh0, 0);
      send_edge(6'd2, 6'd1, 32'sd7, 0);
      send_edge(6'd1, 6'd2, 32'sd7, 0);
      send_edge(6'd42, 6'd21, -32'sd1, 1);
   endtask

   // Graphs with no tree edge
   task automatic test_empty_forest();
      send_edge(6'd9, 6'd9, 32'sd3, 1);
      write_vertex_count(7'd4);
      send_edge(6'd4, 6'd1, 32'sd3, 1);
   endtask

   // Vertex count edges: one, zero, above the store size, full size
   task automatic test_vertex_range();
      write_vertex_count(7'd1);
      send_edge(6'd0, 6'd0, 32'sd1, 0);
      send_edge(6'd0, 6'd1, 32'sd1, 1);
      write_vertex_count(7'd0);
      send_edge(6'd0, 6'd0, 32'sd1, 0);
      send_edge(6'd0, 6'd1, 32'sd2, 1);
      write_vertex_count(7'd127);
      send_edge(6'd63, 6'd62, 32'sd5, 0);
      send_edge(6'd0, 6'd62, 32'sd4, 1);
      write_vertex_count(7'd64);
   endtask

   // Full spanning tree: a path through every vertex plus cycle edges
   task automatic test_full_tree();
      calm = 1;
      for (int v = 0; v < 63; v++) send_edge(v[5:0], v[5:0] + 6'd1, pick_weight(), 0);
      send_edge(6'd0, 6'd63, pick_weight(), 0);
      send_edge(6'd30, 6'd10, pick_weight(), 1);
      calm = 0;
      drain();
   endtask

   // Store overflow sets the drop flag, which clears for the next graph
   task automatic test_overflow();
      calm = 1;
      for (int e = 0; e < MAX_EDGES + 3; e++)
         send_edge(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), pick_weight(),
                   e == MAX_EDGES + 2);
      calm = 0;
      drain();
      send_edge(6'd3, 6'd4, 32'sd1, 1);
   endtask

   // Random graphs with random counts, mostly in range, some noise
   task automatic test_random_graphs();
      int sent, len, live;
      logic [5:0] fv, tv;
      sent = 0;
      while (sent < 200) begin
         if ($urandom_range(0, 3) == 0) write_vertex_count(7'($urandom_range(1, 64)));
         if ($urandom_range(0, 5) == 0) begin
            // pause the sender until everything is back
            drain();
         end
         calm = ($urandom_range(0, 4) == 0);
         len = $urandom_range(1, 12);
         live = (shadow_vc > 64) ? 64 : int'(shadow_vc);
         for (int e = 0; e < len; e++) begin
            if ($urandom_range(0, 7) == 0) begin
               fv = 6'($urandom); tv = 6'($urandom);
            end else begin
               fv = 6'($urandom_range(0, live - 1));
               tv = 6'($urandom_range(0, live - 1));
            end
            send_edge(fv, tv, pick_weight(), e == len - 1);
            sent++;
         end
      end
      calm = 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_empty_forest();
      test_vertex_range();
      test_full_tree();
      test_overflow();
      test_random_graphs();
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_minimum_spanning_forest_top passed");
      end else begin
         $display("tb_minimum_spanning_forest_top failed");
      end
      $finish;
   end

   // Guard against a hung run
   initial begin
      #20ms;
      $display("tb_minimum_spanning_forest_top failed");
      $finish;
   end

endmodule
